/* rtl/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Holds the operation codes, the operand and result beat structs, and the
// struct that carries a classified job from the front end to the back end.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int OpW  = 16;
    localparam int NumW = 33;
    localparam int DenW = 31;
    // magnitude width of a product of two operand magnitudes
    localparam int MagW = 2 * OpW;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MUL  = 3'd2,
        KIND_DIV  = 3'd3,
        KIND_NORM = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [OpW-1:0] a_num;
        logic signed [OpW-1:0] a_den;
        logic signed [OpW-1:0] b_num;
        logic signed [OpW-1:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [NumW-1:0] res_num;
        logic [DenW-1:0]        res_den;
        logic                   status;
    } rau_out_t;

    // classified job handed to the back end
    typedef struct packed {
        logic            err;
        logic            zero;
        logic            neg;
        logic [MagW:0]   nmag;
        logic [MagW-1:0] dmag;
    } rau_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } be_state_t;

endpackage

/* rtl/rau_front.sv */
// ---------------------------------------------------------------------------
// rau_front: operand intake and classification
// Takes a beat, registers its magnitudes and signs, then registers the exact
// cross products and pushes a classified job into the queue.
// ---------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  rau_in_t  in_beat,
    output logic     in_ready,
    output logic     job_valid,
    output rau_job_t job,
    input  logic     job_ready
);

    // stage 1 registers: magnitudes and signs
    logic            s1_valid_reg, s1_valid_next;
    logic [2:0]      s1_kind_reg;
    logic [OpW-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic            ans_reg, ads_reg, bns_reg, bds_reg;
    // stage 2 registers: products
    logic            s2_valid_reg, s2_valid_next;
    logic [MagW-1:0] p1_reg, p2_reg, pd_reg;
    logic            p1s_reg, p2s_reg, pds_reg, err_reg;

    function automatic logic [OpW-1:0] mag(input logic [OpW-1:0] v);
        mag = v[OpW-1] ? (~v + 1'b1) : v;
    endfunction

    assign in_ready = !s1_valid_reg || !s2_valid_reg || job_ready;
    logic adv2;
    assign adv2 = !s2_valid_reg || job_ready;

    always_comb
    begin
        s1_valid_next = adv2 ? in_valid : (s1_valid_reg || in_valid);
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (in_valid && (adv2 || !s1_valid_reg))
        begin
            s1_kind_reg <= in_beat.kind;
            an_reg  <= mag(in_beat.a_num);
            ad_reg  <= mag(in_beat.a_den);
            bn_reg  <= mag(in_beat.b_num);
            bd_reg  <= mag(in_beat.b_den);
            ans_reg <= in_beat.a_num[OpW-1];
            ads_reg <= in_beat.a_den[OpW-1];
            bns_reg <= in_beat.b_num[OpW-1];
            bds_reg <= in_beat.b_den[OpW-1];
        end
    end

    // stage 2: products selected by kind
    logic [OpW-1:0] m1a, m1b, m2a, m2b, mda, mdb;
    logic           s1n, s2n, sdn, e1;
    always_comb
    begin
        m1a = an_reg; m1b = bd_reg; m2a = bn_reg; m2b = ad_reg;
        mda = ad_reg; mdb = bd_reg;
        s1n = ans_reg ^ bds_reg;
        s2n = bns_reg ^ ads_reg;
        sdn = ads_reg ^ bds_reg;
        e1  = (ad_reg == '0);
        case (s1_kind_reg)
            KIND_ADD: e1 = e1 || (bd_reg == '0);
            KIND_SUB:
            begin
                s2n = !s2n;
                e1  = e1 || (bd_reg == '0);
            end
            KIND_MUL:
            begin
                m1b = bn_reg; m2a = '0;
                s1n = ans_reg ^ bns_reg;
                e1  = e1 || (bd_reg == '0);
            end
            KIND_DIV:
            begin
                m2a = '0; mdb = bn_reg;
                sdn = ads_reg ^ bns_reg;
                e1  = e1 || (bd_reg == '0) || (bn_reg == '0);
            end
            default:
            begin
                m1b = {{(OpW-1){1'b0}}, 1'b1}; m2a = '0;
                mdb = {{(OpW-1){1'b0}}, 1'b1};
                s1n = ans_reg; sdn = ads_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            p1_reg  <= m1a * m1b;
            p2_reg  <= m2a * m2b;
            pd_reg  <= mda * mdb;
            p1s_reg <= s1n;
            p2s_reg <= s2n;
            pds_reg <= sdn;
            err_reg <= e1;
        end
    end

    // signed magnitude sum of the two numerator products
    logic [MagW:0] sum;
    logic          sneg;
    always_comb
    begin
        if (p1s_reg == p2s_reg)
        begin
            sum  = {1'b0, p1_reg} + {1'b0, p2_reg};
            sneg = p1s_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum  = {1'b0, p1_reg - p2_reg};
            sneg = p1s_reg;
        end
        else
        begin
            sum  = {1'b0, p2_reg - p1_reg};
            sneg = p2s_reg;
        end
        job.err  = err_reg;
        job.zero = (sum == '0);
        job.neg  = sneg ^ pds_reg;
        job.nmag = sum;
        job.dmag = pd_reg;
    end

    assign job_valid = s2_valid_reg;

endmodule

/* rtl/rau_queue.sv */
// ---------------------------------------------------------------------------
// rau_queue: two-entry job queue
// Decouples the front end from the iterative back end.
// ---------------------------------------------------------------------------
module rau_queue
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    input  rau_job_t wr_job,
    output logic     wr_ready,
    output logic     rd_valid,
    output rau_job_t rd_job,
    input  logic     rd_ready
);

    rau_job_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end

endmodule

/* rtl/rau_back.sv */
// ---------------------------------------------------------------------------
// rau_back: gcd reduction engine
// Binary gcd one step a cycle, then two restoring divisions by the gcd,
// one quotient bit a cycle, then one result beat; error and zero jobs skip straight to their beat.
// ---------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  rau_job_t job,
    output logic     job_ready,
    output logic     res_valid,
    output rau_out_t res
);

    localparam int W  = MagW + 1;
    localparam int CW = $clog2(W + 1);

    be_state_t     state_reg, state_next;
    logic [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [CW-1:0] k_reg, k_next;
    logic [W-1:0]  n_reg, n_next, d_reg, d_next;
    logic [W-1:0]  q_reg, q_next, r_reg, r_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  nq_reg, nq_next;
    rau_out_t      res_reg, res_next;
    logic          rv_reg, rv_next;
    logic [W-1:0]  g, diff, rs;

    assign g = x_reg << k_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid && !job.err && !job.zero) state_next = ST_GCD;
            ST_GCD:  if (y_reg == '0) state_next = ST_DIVN;
            ST_DIVN: if (bit_reg == '0) state_next = ST_DIVD;
            ST_DIVD: if (bit_reg == '0) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        x_next = x_reg; y_next = y_reg; k_next = k_reg;
        n_next = n_reg; d_next = d_reg; q_next = q_reg; r_next = r_reg;
        bit_next = bit_reg; neg_next = neg_reg; nq_next = nq_reg;
        res_next = res_reg; rv_next = 1'b0;
        job_ready = 1'b0;
        rs   = {r_reg[W-2:0], (state_reg == ST_DIVN) ? n_reg[bit_reg] : d_reg[bit_reg]};
        diff = rs - g;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    x_next = job.nmag; y_next = {1'b0, job.dmag};
                    n_next = job.nmag; d_next = {1'b0, job.dmag};
                    neg_next = job.neg; k_next = '0;
                    if (job.err || job.zero)
                    begin
                        rv_next = 1'b1;
                        res_next.res_num = '0;
                        res_next.res_den = job.err ? '0 : DenW'(1);
                        res_next.status  = job.err;
                    end
                end
            end
            ST_GCD:
            begin
                // binary gcd step: x holds the smaller odd value, y the halved difference
                if (y_reg != '0)
                begin
                    if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1; y_next = y_reg >> 1; k_next = k_reg + 1'b1;
                    end
                    else if (!x_reg[0])
                        x_next = x_reg >> 1;
                    else if (!y_reg[0])
                        y_next = y_reg >> 1;
                    else if (x_reg >= y_reg)
                    begin
                        x_next = y_reg; y_next = (x_reg - y_reg) >> 1;
                    end
                    else
                        y_next = (y_reg - x_reg) >> 1;
                end
                else
                begin
                    r_next = '0; q_next = '0; bit_next = CW'(W - 1);
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                if (rs >= g)
                begin
                    r_next = diff; q_next = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_next = rs; q_next = {q_reg[W-2:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                // numerator quotient done, restart for the denominator
                if (bit_reg == '0 && state_reg == ST_DIVN)
                begin
                    nq_next = q_next;
                    r_next = '0; q_next = '0; bit_next = CW'(W - 1);
                end
            end
            ST_DONE:
            begin
                rv_next = 1'b1;
                res_next.res_num = neg_reg ? NumW'(~nq_reg + 1'b1) : NumW'(nq_reg);
                res_next.res_den = q_reg[DenW-1:0];
                res_next.status  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; k_reg <= k_next;
        n_reg <= n_next; d_reg <= d_next; q_reg <= q_next; r_reg <= r_next;
        bit_reg <= bit_next; neg_reg <= neg_next; nq_reg <= nq_next;
        res_reg <= res_next;
    end

    assign res_valid = rv_reg;
    assign res       = res_reg;

endmodule

/* rtl/rational_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: rational add, subtract, multiply, divide, reduce
// Front end forms exact products, back end reduces by the gcd.
// ---------------------------------------------------------------------------
// An operand beat is taken when start is high and busy is low. The front end
// registers the operand magnitudes, then the cross products, and queues the
// job; the back end then runs a binary gcd and two 33-step divisions by the
// gcd before a nonzero result appears, while error and zero results skip
// both. Each result is shown for one cycle with done high and cannot be held
// off by the receiver.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rau_in_t  operands,
    output logic     done,
    output rau_out_t result
);

    logic     f_valid, f_ready, q_valid, q_ready, in_ready;
    rau_job_t f_job, q_job;

    assign busy = !in_ready;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .in_beat(operands),
        .in_ready(in_ready), .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
    );

    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_job(f_job),
        .wr_ready(f_ready), .rd_valid(q_valid), .rd_job(q_job), .rd_ready(q_ready)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_job),
        .job_ready(q_ready), .res_valid(done), .res(result)
    );

endmodule

/* rtl/rau_checker.sv */
// ---------------------------------------------------------------------------
// rau_checker: port-level checks
// Watches the result beats of the rational arithmetic unit.
// ---------------------------------------------------------------------------
module rau_checker
    import rau_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input rau_out_t result
);

    // error beats carry zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> result.res_num == '0 && result.res_den == '0)
        else $error("error beat not cleared");

    // good beats have positive denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.status |-> result.res_den != '0)
        else $error("zero denominator on good beat");

    // zero numerator only with unit denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.status && result.res_num == '0 |-> result.res_den == DenW'(1))
        else $error("zero result not canonical");

    // handshake lines always known out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({start, busy, done}))
        else $error("unknown handshake line");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
